// ===== hdl/iodrob_pkg.sv =====
`default_nettype none

package iodrob_pkg;

    localparam logic OP_ALLOC    = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_DELIVER = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_ID  = 2'd3;

    typedef struct packed {
        logic        op;
        logic [31:0] seq_id;
        logic        deliver;
        logic [15:0] receiver_handle;
        logic [31:0] payload_handle;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_id;
        logic [15:0] out_receiver;
        logic [31:0] out_payload;
        logic        last;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/in_order_delivery_reorder_buffer_unit.sv =====
// in-order delivery reorder buffer
// input channel s_valid/s_ready/s_item carries allocate and complete items;
// result channel m_valid/m_ready/m_item carries allocations, deliveries and errors.
// an allocate returns the next 32-bit sequence number, or a window-full status
// when WINDOW numbers are outstanding. a complete of the oldest outstanding
// number retires it and every following number whose completion is stored;
// each retiring item with deliver set gives one delivery, the final one of
// the item marked last. other in-window completions are stored, no result.
// an accepted item is registered and evaluated in S_CALC, which allocates,
// refuses, reports an error or stores it; any result goes to the output
// register. a drain walks the slot memory, for each stored completion a slot
// check, then a registered memory read, and then closes.
// s_ready is high only while the sequencer waits for an item.
// a full output register stalls the sequencer until m_ready takes the item.
// reset (aresetn low, synchronous) empties the window, numbering starts at 0.
`default_nettype none

module in_order_delivery_reorder_buffer_unit #(
    parameter int WINDOW        = 16,
    parameter int RECEIVER_BITS = 16,
    parameter int PAYLOAD_BITS  = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire iodrob_pkg::in_item_t  s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output iodrob_pkg::out_item_t      m_item
);

    import iodrob_pkg::*;

    localparam int SW  = $clog2(WINDOW);
    localparam int RKB = (RECEIVER_BITS < 16) ? RECEIVER_BITS : 16;
    localparam int PKB = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int EW  = 1 + RKB + PKB;
    localparam logic [SW:0]   WIN_S   = (SW + 1)'(WINDOW);
    localparam logic [SW-1:0] LAST_SL = SW'(WINDOW - 1);
    localparam logic [31:0]   WIN_32  = 32'(WINDOW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_WALK,
        S_FETCH
    } state_t;

    state_t          state_reg, state_next;
    in_item_t        in_reg, in_next;
    logic [31:0]     next_issue_reg, next_issue_next;
    logic [31:0]     oldest_reg, oldest_next;
    logic [SW-1:0]   oldest_slot_reg, oldest_slot_next;
    logic [WINDOW-1:0] slot_done_reg, slot_done_next;
    logic [31:0]     cur_reg, cur_next;
    logic [SW-1:0]   cur_slot_reg, cur_slot_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [31:0]     pend_id_reg, pend_id_next;
    logic [RKB-1:0]  pend_rcv_reg, pend_rcv_next;
    logic [PKB-1:0]  pend_pay_reg, pend_pay_next;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_item_reg, m_item_next;

    logic            ram_we;
    logic            ram_re;
    logic [EW-1:0]   ram_wdata;
    logic [EW-1:0]   ram_rdata;

    logic [31:0]     outstanding;
    logic [31:0]     offset;
    logic            outside;
    logic            wrapped;
    logic [SW:0]     slot_sum;
    logic [SW-1:0]   seq_slot;
    logic [RKB-1:0]  rcv_keep;
    logic [PKB-1:0]  pay_keep;
    logic            out_free;
    logic            rd_deliver;
    logic [RKB-1:0]  rd_rcv;
    logic [PKB-1:0]  rd_pay;

    function automatic logic [SW-1:0] adv_slot(input logic [SW-1:0] slot,
                                               input logic [31:0] id);
        logic [SW-1:0] res;
        if (id == 32'hFFFF_FFFF || slot == LAST_SL) begin
            res = '0;
        end else begin
            res = slot + SW'(1);
        end
        return res;
    endfunction

    function automatic out_item_t make_result(input logic [1:0] status,
                                              input logic [31:0] id,
                                              input logic [RKB-1:0] rcv,
                                              input logic [PKB-1:0] pay,
                                              input logic last);
        out_item_t r;
        r.status       = status;
        r.out_id       = id;
        r.out_receiver = 16'(rcv);
        r.out_payload  = 32'(pay);
        r.last         = last;
        return r;
    endfunction

    assign outstanding = next_issue_reg - oldest_reg;
    assign offset      = in_reg.seq_id - oldest_reg;
    assign wrapped     = in_reg.seq_id < oldest_reg;
    assign slot_sum    = {1'b0, oldest_slot_reg} + {1'b0, offset[SW-1:0]};
    assign seq_slot    = wrapped ? in_reg.seq_id[SW-1:0] :
                         (slot_sum >= WIN_S) ? SW'(slot_sum - WIN_S) : slot_sum[SW-1:0];
    assign outside     = (offset >= outstanding) || slot_done_reg[seq_slot];
    assign rcv_keep    = in_reg.receiver_handle[RKB-1:0];
    assign pay_keep    = in_reg.payload_handle[PKB-1:0];
    assign out_free    = !m_valid_reg || m_ready;
    assign ram_wdata   = {in_reg.deliver, rcv_keep, pay_keep};
    assign rd_deliver  = ram_rdata[EW-1];
    assign rd_rcv      = ram_rdata[PKB +: RKB];
    assign rd_pay      = ram_rdata[PKB-1:0];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    iodrob_ram #(
        .WIDTH (EW),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (seq_slot),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cur_slot_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        in_next          = in_reg;
        next_issue_next  = next_issue_reg;
        oldest_next      = oldest_reg;
        oldest_slot_next = oldest_slot_reg;
        slot_done_next   = slot_done_reg;
        cur_next         = cur_reg;
        cur_slot_next    = cur_slot_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        pend_rcv_next    = pend_rcv_reg;
        pend_pay_next    = pend_pay_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_item_next      = m_item_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next    = s_item;
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (in_reg.op == OP_ALLOC) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        if (outstanding >= WIN_32) begin
                            m_item_next = make_result(ST_FULL, '0, '0, '0, 1'b1);
                        end else begin
                            m_item_next = make_result(ST_ALLOC, next_issue_reg, '0, '0, 1'b1);
                            next_issue_next = next_issue_reg + 32'd1;
                        end
                        state_next = S_IDLE;
                    end
                end else if (outside) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_item_next  = make_result(ST_BAD_ID, in_reg.seq_id, '0, '0, 1'b1);
                        state_next   = S_IDLE;
                    end
                end else if (offset != '0) begin
                    ram_we                   = 1'b1;
                    slot_done_next[seq_slot] = 1'b1;
                    state_next               = S_IDLE;
                end else begin
                    pend_valid_next = in_reg.deliver;
                    pend_id_next    = in_reg.seq_id;
                    pend_rcv_next   = rcv_keep;
                    pend_pay_next   = pay_keep;
                    cur_next        = in_reg.seq_id + 32'd1;
                    cur_slot_next   = adv_slot(seq_slot, in_reg.seq_id);
                    state_next      = S_WALK;
                end
            end
            S_WALK: begin
                if (cur_reg != next_issue_reg && slot_done_reg[cur_slot_reg]) begin
                    ram_re     = 1'b1;
                    state_next = S_FETCH;
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_item_next  = make_result(ST_DELIVER, pend_id_reg, pend_rcv_reg,
                                                   pend_pay_reg, 1'b1);
                    end
                    pend_valid_next  = 1'b0;
                    oldest_next      = cur_reg;
                    oldest_slot_next = cur_slot_reg;
                    state_next       = S_IDLE;
                end
            end
            S_FETCH: begin
                if (!rd_deliver || !pend_valid_reg || out_free) begin
                    if (rd_deliver) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_item_next  = make_result(ST_DELIVER, pend_id_reg, pend_rcv_reg,
                                                       pend_pay_reg, 1'b0);
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = cur_reg;
                        pend_rcv_next   = rd_rcv;
                        pend_pay_next   = rd_pay;
                    end
                    slot_done_next[cur_slot_reg] = 1'b0;
                    cur_next      = cur_reg + 32'd1;
                    cur_slot_next = adv_slot(cur_slot_reg, cur_reg);
                    state_next    = S_WALK;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            next_issue_reg  <= '0;
            oldest_reg      <= '0;
            oldest_slot_reg <= '0;
            slot_done_reg   <= '0;
            cur_reg         <= '0;
            cur_slot_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            next_issue_reg  <= next_issue_next;
            oldest_reg      <= oldest_next;
            oldest_slot_reg <= oldest_slot_next;
            slot_done_reg   <= slot_done_next;
            cur_reg         <= cur_next;
            cur_slot_reg    <= cur_slot_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
        end
        in_reg       <= in_next;
        pend_id_reg  <= pend_id_next;
        pend_rcv_reg <= pend_rcv_next;
        pend_pay_reg <= pend_pay_next;
        m_item_reg   <= m_item_next;
    end

    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        outstanding <= WIN_32)
        else $error("outstanding count beyond window");

    a_oldest_not_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !slot_done_reg[oldest_slot_reg])
        else $error("oldest slot holds a stored completion while idle");

    a_done_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |->
            ($countones(slot_done_reg) == 0 || 32'($countones(slot_done_reg)) < outstanding))
        else $error("stored completions exceed outstanding numbers");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.status != ST_DELIVER |-> m_item_reg.last)
        else $error("non-delivery result without last");

    a_drain_holds_oldest: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FETCH |=> $stable(oldest_reg))
        else $error("oldest number moved during drain");

endmodule

`default_nettype wire

// ===== hdl/iodrob_ram.sv =====
`default_nettype none

module iodrob_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
